/* rtl/core/ptd_pkg.sv */
// Package for the trial-division primality tester.
// Holds the default number width and the fixed width of the echoed field.
// No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int FIELD_BITS         = 32;

endpackage : ptd_pkg

/* rtl/core/ptd_divider.sv */
// Restoring divider for the primality tester: one quotient bit per cycle.
// Depends on ptd_pkg for the default width.
`timescale 1ns / 1ps

module ptd_divider
  import ptd_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder
);

  localparam int CountBits = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CountBits-1:0]  count;
  logic [VALUE_BITS-1:0] dvs;
  logic [VALUE_BITS:0]   trial;
  logic                  fits;
  logic [VALUE_BITS:0]   diff;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {remainder, quotient[VALUE_BITS-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        remainder <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        quotient  <= {quotient[VALUE_BITS-2:0], fits};
        count     <= count - CountBits'(1);
        if (count == CountBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy      <= 1'b1;
        count     <= CountBits'(VALUE_BITS);
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end
    end
  end

endmodule : ptd_divider

/* rtl/core/primality_trial_division.sv */
// Trial-division primality tester: top level with the divisor sequencer.
// Depends on ptd_pkg and ptd_divider.
//
// Usage: drive value and raise start while busy is low; the request is taken
// at that clock edge, and busy rises unless the answer is immediate. Exactly
// one result follows: done is high for one cycle with tested_value (the
// number, cut to VALUE_BITS and echoed) and is_prime. The receiver cannot
// stall; the result must be taken in that cycle. busy falls with done, and a
// new request may be taken in that cycle.
// The numbers 0, 1, 2, 3 and even numbers are answered in the cycle after the request.
// Odd numbers from 5 try odd divisors from 3 upward while d <= n / d, each
// trial one pass of the single restoring divider, which produces quotient
// and remainder together.
// Reset: rst (synchronous, active high) drops any request in flight and
// returns the block to idle with busy and done low.
`timescale 1ns / 1ps

module primality_trial_division
  import ptd_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] value,
  output logic                  busy,
  output logic                  done,
  output logic [FIELD_BITS-1:0] tested_value,
  output logic                  is_prime
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] num;
  logic [VALUE_BITS-1:0] num_in;
  logic [VALUE_BITS-1:0] divisor;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  assign num_in = VALUE_BITS'(value);
  assign busy   = (state != S_IDLE);

  ptd_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            num          <= num_in;
            tested_value <= FIELD_BITS'(num_in);
            divisor      <= VALUE_BITS'(3);
            if ((num_in >> 1) == '0) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else if ((num_in >> 2) == '0) begin
              done     <= 1'b1;
              is_prime <= 1'b1;
            end else if (!num_in[0]) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else begin
              state     <= S_RUN;
              div_start <= 1'b1;
            end
          end
        end
        S_RUN: begin
          if (div_done) begin
            // Past the square root: no divisor found.
            if (divisor > div_quo) begin
              done     <= 1'b1;
              is_prime <= 1'b1;
              state    <= S_IDLE;
            end else if (div_rem == '0) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
              state    <= S_IDLE;
            end else begin
              divisor   <= divisor + VALUE_BITS'(2);
              div_start <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : primality_trial_division
